@@ hw/rtl/gtg_pkg.sv @@
// shared types, constants and the arctangent table for the go-to-goal controller
package gtg_pkg;

  // fixed-point angle constants
  localparam int PI_Q12     = 12868;
  localparam int TWO_PI_Q12 = 25736;
  localparam logic signed [32:0] PI_Q28 = 33'sd843314856;

  // navigation modes
  localparam logic [1:0] MODE_STOPPED  = 2'd0;
  localparam logic [1:0] MODE_MOVING   = 2'd1;
  localparam logic [1:0] MODE_ROTATING = 2'd2;

  // input item commands
  localparam logic CMD_GOAL = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_ATTRACTION_GAIN  = 3'd0;
  localparam logic [2:0] REG_HEADING_GAIN     = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED        = 3'd2;
  localparam logic [2:0] REG_MIN_SPEED        = 3'd3;
  localparam logic [2:0] REG_ARRIVE_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_TURN_THRESHOLD   = 3'd5;
  localparam logic [2:0] REG_TURN_RATE        = 3'd6;

  // iterations of the shared sqrt / cordic loop (32 result bits of the root)
  localparam int LOOP_LAST = 31;

  typedef struct packed {
    logic [15:0] attraction_gain;
    logic [15:0] heading_gain;
    logic [19:0] max_speed;
    logic [19:0] min_speed;
    logic [19:0] arrive_tolerance;
    logic [13:0] turn_threshold;
    logic [15:0] turn_rate;
  } gtg_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic sq_x;
    logic sq_y;
    logic sum;
    logic tol;
    logic init;
    logic step;
    logic speed;
    logic head;
    logic turn;
    logic emit;
    logic emit_zero;
  } gtg_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic tick;
    logic stopped;
    logic arrived;
    logic last;
    logic out_free;
  } gtg_sts_t;

  // arctangent of 2^-i in Q4.28
  function automatic logic [29:0] atan_q28(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd210828714;
      5'd1: v = 30'd124459457;
      5'd2: v = 30'd65760959;
      5'd3: v = 30'd33381290;
      5'd4: v = 30'd16755422;
      5'd5: v = 30'd8385879;
      5'd6: v = 30'd4193963;
      5'd7: v = 30'd2097109;
      5'd8: v = 30'd1048571;
      5'd9: v = 30'd524287;
      default: begin
        if (i <= 5'd28) v = 30'd1 << (5'd28 - i);
        else v = 30'd0;
      end
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/gtg_ctrl.sv @@
// sequencing state machine of the go-to-goal controller
module gtg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gtg_pkg::gtg_sts_t sts,
  output gtg_pkg::gtg_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_TOL, S_ARR, S_ITER,
    S_SPEED, S_HEAD, S_TURN, S_EMIT, S_ZERO
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.tick) state_nxt = sts.stopped ? S_ZERO : S_SQX;
      end
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_TOL;
      S_TOL:   state_nxt = S_ARR;
      S_ARR:   state_nxt = sts.arrived ? S_ZERO : S_ITER;
      S_ITER:  if (sts.last) state_nxt = S_SPEED;
      S_SPEED: state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_TURN;
      S_TURN:  state_nxt = S_EMIT;
      S_EMIT, S_ZERO: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // command decode
  always_comb begin
    cmd = '0;
    cmd.take      = (state_r == S_IDLE) && in_valid;
    cmd.sq_x      = (state_r == S_SQX);
    cmd.sq_y      = (state_r == S_SQY);
    cmd.sum       = (state_r == S_SUM);
    cmd.tol       = (state_r == S_TOL);
    cmd.init      = (state_r == S_ARR);
    cmd.step      = (state_r == S_ITER);
    cmd.speed     = (state_r == S_SPEED);
    cmd.head      = (state_r == S_HEAD);
    cmd.turn      = (state_r == S_TURN);
    cmd.emit      = (state_r == S_EMIT) && sts.out_free;
    cmd.emit_zero = (state_r == S_ZERO) && sts.out_free;
  end

endmodule

@@ hw/rtl/gtg_dp.sv @@
// datapath: distance, arrival test, iterative sqrt and cordic bearing, speed and yaw rate
module gtg_dp #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gtg_pkg::gtg_cfg_t  cfg,
  input  gtg_pkg::gtg_cmd_t  cmd,
  output gtg_pkg::gtg_sts_t  sts,
  input  logic               in_command,
  input  logic signed [31:0] in_goal_x,
  input  logic signed [31:0] in_goal_y,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [14:0] in_robot_yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [19:0]        out_linear_speed,
  output logic signed [20:0] out_angular_speed,
  output logic [1:0]         out_nav_mode
);

  localparam int XW = 36;
  localparam int ZW = 33;

  logic [1:0]         mode_r;
  logic signed [31:0] target_x_r, target_y_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [14:0] yaw_r;
  logic [63:0]        sqx_r, prod_r, sum_r;
  logic [63:0]        val_r;
  logic [33:0]        rem_r;
  logic [31:0]        root_r;
  logic [4:0]         cnt_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic               zero_brg_r;
  logic [19:0]        lin_r;
  logic signed [15:0] e_r;
  logic signed [33:0] p_r;
  logic               out_valid_r;
  logic [19:0]        out_lin_r;
  logic signed [20:0] out_ang_r;
  logic [1:0]         out_mode_r;

  // absolute offsets
  logic signed [32:0] ndx, ndy;
  logic [31:0]        ax, ay;
  assign ndx = -dx_r;
  assign ndy = -dy_r;
  assign ax  = dx_r[32] ? ndx[31:0] : dx_r[31:0];
  assign ay  = dy_r[32] ? ndy[31:0] : dy_r[31:0];

  // shared unsigned multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    if (cmd.sq_y) begin
      mul_a = ay;
      mul_b = ay;
    end else if (cmd.tol) begin
      mul_a = {12'd0, cfg.arrive_tolerance};
      mul_b = {12'd0, cfg.arrive_tolerance};
    end else if (cmd.speed) begin
      mul_a = {16'd0, cfg.attraction_gain};
      mul_b = root_r;
    end
  end
  assign prod = mul_a * mul_b;

  // status
  logic [31:0] tol32;
  assign tol32        = {12'd0, cfg.arrive_tolerance};
  assign sts.tick     = (in_command == gtg_pkg::CMD_TICK);
  assign sts.stopped  = (mode_r == gtg_pkg::MODE_STOPPED);
  assign sts.arrived  = (ax < tol32) && (ay < tol32) && (sum_r < prod_r);
  assign sts.last     = (cnt_r == 5'(gtg_pkg::LOOP_LAST));
  assign sts.out_free = !out_valid_r || out_ready;

  // sqrt digit step
  logic [34:0] rem_sh, trial, rem_sub;
  assign rem_sh  = {rem_r[32:0], val_r[63:62]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign rem_sub = rem_sh - trial;

  // cordic rotation step
  logic signed [XW-1:0] xs, ys, dx36, dy36;
  logic signed [ZW-1:0] atan_z;
  logic                 cordic_on;
  assign xs        = cx_r >>> cnt_r;
  assign ys        = cy_r >>> cnt_r;
  assign atan_z    = $signed({3'd0, gtg_pkg::atan_q28(cnt_r)});
  assign cordic_on = ({1'b0, cnt_r} < 6'(CORDIC_STEPS));
  assign dx36      = {{(XW-33){dx_r[32]}}, dx_r};
  assign dy36      = {{(XW-33){dy_r[32]}}, dy_r};

  // bearing rounding and heading error wrap
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   brg;
  logic signed [18:0]   e_raw, e_wrap;
  assign zr  = cz_r + ZW'(32768);
  assign brg = zero_brg_r ? 17'sd0 : zr[32:16];
  always_comb begin
    e_raw  = {{4{yaw_r[14]}}, yaw_r} - {{2{brg[16]}}, brg};
    e_wrap = e_raw;
    if (e_raw > 19'sd12868) e_wrap = e_raw - 19'(gtg_pkg::TWO_PI_Q12);
    else if (e_raw <= -19'sd12868) e_wrap = e_raw + 19'(gtg_pkg::TWO_PI_Q12);
  end

  // linear speed clamp
  logic [39:0] raw40;
  logic        gain_zero, too_fast;
  logic [19:0] lin1, lin2;
  assign raw40     = prod_r[47:8];
  assign gain_zero = (cfg.attraction_gain == 16'd0);
  assign too_fast  = !gain_zero && (ax[31] || ay[31] || raw40 > {20'd0, cfg.max_speed});
  assign lin1      = too_fast ? cfg.max_speed : (gain_zero ? 20'd0 : raw40[19:0]);
  assign lin2      = (lin1 < cfg.min_speed) ? cfg.min_speed : lin1;

  // heading product
  logic signed [32:0] hp;
  assign hp = $signed({1'b0, cfg.heading_gain}) * e_r;

  // yaw rate rounding, saturation and turn-in-place override
  logic signed [33:0] psum, pshift;
  logic signed [20:0] ang_sat, tr21, ang_emit;
  logic signed [15:0] e_neg;
  logic [15:0]        mag;
  logic               turn_done;
  logic [19:0]        lin_emit;
  logic [1:0]         mode_emit;
  assign psum   = p_r + 34'sd128;
  assign pshift = psum >>> 8;
  assign e_neg  = -e_r;
  assign mag    = e_r[15] ? e_neg : e_r;
  assign tr21   = $signed({5'd0, cfg.turn_rate});
  assign turn_done = (mag < {2'd0, cfg.turn_threshold});
  always_comb begin
    if (pshift > 34'sd1048575) ang_sat = 21'sd1048575;
    else if (pshift < -34'sd1048576) ang_sat = -21'sd1048576;
    else ang_sat = pshift[20:0];
    lin_emit  = lin_r;
    ang_emit  = ang_sat;
    mode_emit = mode_r;
    if (mode_r == gtg_pkg::MODE_ROTATING) begin
      lin_emit = 20'd0;
      ang_emit = p_r[33] ? -tr21 : tr21;
      if (turn_done) begin
        ang_emit  = 21'sd0;
        mode_emit = gtg_pkg::MODE_MOVING;
      end
    end
  end

  // control state: mode, goal and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= gtg_pkg::MODE_STOPPED;
      target_x_r  <= '0;
      target_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take && !sts.tick) begin
        target_x_r <= in_goal_x;
        target_y_r <= in_goal_y;
        mode_r     <= (cfg.turn_threshold != 14'd0) ? gtg_pkg::MODE_ROTATING
                                                    : gtg_pkg::MODE_MOVING;
      end
      if (cmd.emit) mode_r <= mode_emit;
      if (cmd.emit_zero) mode_r <= gtg_pkg::MODE_STOPPED;
      if (cmd.emit || cmd.emit_zero) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dx_r  <= {target_x_r[31], target_x_r} - {in_robot_x[31], in_robot_x};
      dy_r  <= {target_y_r[31], target_y_r} - {in_robot_y[31], in_robot_y};
      yaw_r <= in_robot_yaw;
    end
    if (cmd.sq_x) sqx_r <= prod;
    if (cmd.sq_y || cmd.tol || cmd.speed) prod_r <= prod;
    if (cmd.sum) sum_r <= sqx_r + prod_r;
    if (cmd.init) begin
      val_r      <= sum_r;
      rem_r      <= '0;
      root_r     <= '0;
      cnt_r      <= '0;
      cx_r       <= dx_r[32] ? -dx36 : dx36;
      cy_r       <= dx_r[32] ? -dy36 : dy36;
      cz_r       <= dx_r[32] ? (dy_r[32] ? -gtg_pkg::PI_Q28 : gtg_pkg::PI_Q28) : '0;
      zero_brg_r <= gain_zero || (dx_r == 33'sd0 && dy_r == 33'sd0);
    end
    if (cmd.step) begin
      cnt_r <= cnt_r + 5'd1;
      val_r <= {val_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sub[33:0];
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
      if (cordic_on) begin
        if (!cy_r[XW-1]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + atan_z;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - atan_z;
        end
      end
    end
    if (cmd.head) begin
      lin_r <= lin2;
      e_r   <= e_wrap[15:0];
    end
    if (cmd.turn) p_r <= -{hp[32], hp};
    if (cmd.emit) begin
      out_lin_r  <= lin_emit;
      out_ang_r  <= ang_emit;
      out_mode_r <= mode_emit;
    end
    if (cmd.emit_zero) begin
      out_lin_r  <= '0;
      out_ang_r  <= '0;
      out_mode_r <= gtg_pkg::MODE_STOPPED;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_linear_speed  = out_lin_r;
  assign out_angular_speed = out_ang_r;
  assign out_nav_mode      = out_mode_r;

endmodule

@@ hw/rtl/go_to_goal_velocity_controller.sv @@
// top level of the go-to-goal velocity controller: registers, controller and datapath
//
// Usage:
//  - in channel: a goal transaction (in_command = 0) stores the goal and arms the
//    controller with no result; a tick transaction (in_command = 1)
//    carries the robot pose and yields exactly one result transaction.
//  - out channel: linear speed, yaw rate and navigation mode after the tick.
//  - cfg channel: always ready, writes register cfg_index with cfg_data; indexes
//    past the last register are dropped. Write only while the block is idle.
//  - sequence: a tick on a stopped controller goes straight to its zero result; an armed
//    tick that has not arrived runs the 32-step loop that computes the digit-by-digit square
//    root and the cordic bearing together (the cordic in its first CORDIC_STEPS steps).
//  - one item is worked on at a time: in_ready is high only when idle.
//  - the result sits in an output register; a stalled receiver holds it there and
//    the next tick waits at its final step until that register is taken.
//  - reset: registers take their defaults, mode is stopped, the goal is the origin
//    and the output register is empty.
module go_to_goal_velocity_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [31:0] in_goal_x,
  input  logic signed [31:0] in_goal_y,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [14:0] in_robot_yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [19:0]        out_linear_speed,
  output logic signed [20:0] out_angular_speed,
  output logic [1:0]         out_nav_mode,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  gtg_pkg::gtg_cfg_t cfg_r;
  gtg_pkg::gtg_cmd_t cmd;
  gtg_pkg::gtg_sts_t sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attraction_gain  <= 16'd128;
      cfg_r.heading_gain     <= 16'd128;
      cfg_r.max_speed        <= 20'd13107;
      cfg_r.min_speed        <= 20'd3277;
      cfg_r.arrive_tolerance <= 20'd6554;
      cfg_r.turn_threshold   <= 14'd1638;
      cfg_r.turn_rate        <= 16'd12288;
    end else if (cfg_valid) begin
      case (cfg_index)
        gtg_pkg::REG_ATTRACTION_GAIN:  cfg_r.attraction_gain  <= cfg_data[15:0];
        gtg_pkg::REG_HEADING_GAIN:     cfg_r.heading_gain     <= cfg_data[15:0];
        gtg_pkg::REG_MAX_SPEED:        cfg_r.max_speed        <= cfg_data;
        gtg_pkg::REG_MIN_SPEED:        cfg_r.min_speed        <= cfg_data;
        gtg_pkg::REG_ARRIVE_TOLERANCE: cfg_r.arrive_tolerance <= cfg_data;
        gtg_pkg::REG_TURN_THRESHOLD:   cfg_r.turn_threshold   <= cfg_data[13:0];
        gtg_pkg::REG_TURN_RATE:        cfg_r.turn_rate        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gtg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtg_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_command),
    .in_goal_x         (in_goal_x),
    .in_goal_y         (in_goal_y),
    .in_robot_x        (in_robot_x),
    .in_robot_y        (in_robot_y),
    .in_robot_yaw      (in_robot_yaw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_linear_speed  (out_linear_speed),
    .out_angular_speed (out_angular_speed),
    .out_nav_mode      (out_nav_mode)
  );

  // a goal transaction never produces a result
  a_goal_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == gtg_pkg::CMD_GOAL |=> !$rose(out_valid))
    else $error("goal transaction produced a result");

  // a tick transaction keeps the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == gtg_pkg::CMD_TICK |=> !in_ready)
    else $error("ready right after a tick");

  // stopped results command no motion
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nav_mode == gtg_pkg::MODE_STOPPED |->
      out_linear_speed == 20'd0 && out_angular_speed == 21'sd0)
    else $error("motion while stopped");

  // turning in place means no forward speed
  a_rotate_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nav_mode == gtg_pkg::MODE_ROTATING |-> out_linear_speed == 20'd0)
    else $error("forward speed while rotating");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the go-to-goal velocity controller
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_RANDOM = 1500;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic        command;
    logic [31:0] goal_x;
    logic [31:0] goal_y;
    logic [31:0] robot_x;
    logic [31:0] robot_y;
    logic [14:0] robot_yaw;
    logic        has_fixed;
    logic [19:0] fix_linear;
    logic [20:0] fix_angular;
    logic [1:0]  fix_mode;
  } pose_row_t;

  typedef struct {
    logic [19:0] linear_speed;
    logic [20:0] angular_speed;
    logic [1:0]  nav_mode;
  } velocity_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic signed [31:0] in_goal_x = '0;
  logic signed [31:0] in_goal_y = '0;
  logic signed [31:0] in_robot_x = '0;
  logic signed [31:0] in_robot_y = '0;
  logic signed [14:0] in_robot_yaw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [19:0] out_linear_speed;
  logic signed [20:0] out_angular_speed;
  logic [1:0] out_nav_mode;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // predictor state and configuration
  logic [15:0] m_attraction_gain, m_heading_gain, m_turn_rate;
  logic [19:0] m_max_speed, m_min_speed, m_arrive_tolerance;
  logic [13:0] m_turn_threshold;
  logic [1:0]  m_mode;
  longint      m_target_x, m_target_y;

  velocity_cmd_t pending_cmds[$];
  int  mismatches = 0;
  int  stall_left = 0;
  bit  idle_enable = 1'b1;
  velocity_cmd_t fixed_cmd;
  longint atan_tab[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                           8385879, 4193963, 2097109, 1048571, 524287};

  go_to_goal_velocity_controller DUT (.*);

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // floor shift for signed values
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // cordic vectoring atan2 in q4.28, rounded to q4.12
  function automatic longint bearing_of(longint x, longint y);
    longint z, xs, ys, a;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 843314856 : -843314856;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (i < 10) a = atan_tab[i];
      else a = 64'sd1 <<< (28 - i);
      if (y >= 0) begin
        x += ys; y -= xs; z += a;
      end else begin
        x -= ys; y += xs; z -= a;
      end
    end
    return (z + (64'sd1 <<< 15)) >>> 16;
  endfunction

  task automatic reset_model();
    m_attraction_gain = 128; m_heading_gain = 128;
    m_max_speed = 13107; m_min_speed = 3277;
    m_arrive_tolerance = 6554; m_turn_threshold = 1638; m_turn_rate = 12288;
    m_mode = gtg_pkg::MODE_STOPPED; m_target_x = 0; m_target_y = 0;
  endtask

  // store a goal, or compute the velocity command for a tick; update mode
  task automatic predict_velocity(input pose_row_t r);
    velocity_cmd_t c;
    longint dx, dy, yaw, brg, e, p, ang, mag;
    longint unsigned ax, ay, tol, lin;
    if (r.command == gtg_pkg::CMD_GOAL) begin
      m_target_x = longint'(signed'(r.goal_x));
      m_target_y = longint'(signed'(r.goal_y));
      m_mode = (m_turn_threshold != 0) ? gtg_pkg::MODE_ROTATING : gtg_pkg::MODE_MOVING;
      return;
    end
    lin = 0;
    ang = 0;
    if (m_mode != gtg_pkg::MODE_STOPPED) begin
      dx = m_target_x - longint'(signed'(r.robot_x));
      dy = m_target_y - longint'(signed'(r.robot_y));
      yaw = longint'(signed'(r.robot_yaw));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      tol = m_arrive_tolerance;
      if (ax < tol && ay < tol && ax * ax + ay * ay < tol * tol) begin
        m_mode = gtg_pkg::MODE_STOPPED;
      end else begin
        if (m_attraction_gain == 0) lin = 0;
        else if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) lin = 64'd1 << 40;
        else lin = (m_attraction_gain * int_sqrt(ax * ax + ay * ay)) >> 8;
        if (lin > m_max_speed) lin = m_max_speed;
        if (lin < m_min_speed) lin = m_min_speed;
        brg = (m_attraction_gain == 0) ? 0 : bearing_of(dx, dy);
        e = yaw - brg;
        while (e > gtg_pkg::PI_Q12) e -= gtg_pkg::TWO_PI_Q12;
        while (e <= -gtg_pkg::PI_Q12) e += gtg_pkg::TWO_PI_Q12;
        p = -(longint'(m_heading_gain) * e);
        ang = (p + 128) >>> 8;
        if (ang > 1048575) ang = 1048575;
        if (ang < -1048576) ang = -1048576;
        if (m_mode == gtg_pkg::MODE_ROTATING) begin
          mag = (e < 0) ? -e : e;
          lin = 0;
          ang = (p < 0) ? -longint'(m_turn_rate) : longint'(m_turn_rate);
          if (mag < m_turn_threshold) begin
            ang = 0;
            m_mode = gtg_pkg::MODE_MOVING;
          end
        end
      end
    end
    c.linear_speed = lin[19:0];
    c.angular_speed = ang[20:0];
    c.nav_mode = m_mode;
    if (r.has_fixed) begin
      fixed_cmd.linear_speed = r.fix_linear;
      fixed_cmd.angular_speed = r.fix_angular;
      fixed_cmd.nav_mode = r.fix_mode;
      pending_cmds.push_back(fixed_cmd);
    end else begin
      pending_cmds.push_back(c);
    end
  endtask

  // drop valid for a short random gap before the next transaction
  task automatic idle_burst();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // one input transaction
  task automatic send_item(input pose_row_t r);
    idle_burst();
    in_valid <= 1'b1;
    in_command <= r.command;
    in_goal_x <= r.goal_x;
    in_goal_y <= r.goal_y;
    in_robot_x <= r.robot_x;
    in_robot_y <= r.robot_y;
    in_robot_yaw <= r.robot_yaw;
    do @(posedge clk); while (!in_ready);
    predict_velocity(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gtg_pkg::REG_ATTRACTION_GAIN:  m_attraction_gain = val[15:0];
      gtg_pkg::REG_HEADING_GAIN:     m_heading_gain = val[15:0];
      gtg_pkg::REG_MAX_SPEED:        m_max_speed = val;
      gtg_pkg::REG_MIN_SPEED:        m_min_speed = val;
      gtg_pkg::REG_ARRIVE_TOLERANCE: m_arrive_tolerance = val;
      gtg_pkg::REG_TURN_THRESHOLD:   m_turn_threshold = val[13:0];
      gtg_pkg::REG_TURN_RATE:        m_turn_rate = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic pose_row_t tick_row(logic [31:0] x, logic [31:0] y, logic [14:0] yaw);
    pose_row_t r;
    r = '{default: '0};
    r.command = gtg_pkg::CMD_TICK;
    r.robot_x = x; r.robot_y = y; r.robot_yaw = yaw;
    r.goal_x = $urandom; r.goal_y = $urandom;
    return r;
  endfunction

  function automatic pose_row_t goal_row(logic [31:0] x, logic [31:0] y);
    pose_row_t r;
    r = '{default: '0};
    r.command = gtg_pkg::CMD_GOAL;
    r.goal_x = x; r.goal_y = y;
    r.robot_x = $urandom; r.robot_y = $urandom; r.robot_yaw = $urandom;
    return r;
  endfunction

  function automatic pose_row_t fixed_row(pose_row_t r, logic [19:0] l, logic [20:0] a,
                                          logic [1:0] m);
    r.has_fixed = 1'b1;
    r.fix_linear = l; r.fix_angular = a; r.fix_mode = m;
    return r;
  endfunction

  function automatic logic [14:0] rand_yaw();
    int v;
    v = $urandom_range(0, 9) == 0 ? $urandom_range(0, 32767) - 16384
                                  : $urandom_range(0, 25736) - 12868;
    return v[14:0];
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    int d;
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, 16000) - 8000;
      1: d = $urandom_range(0, 400000) - 200000;
      2: d = $urandom;
      default: d = $urandom_range(0, 8000000) - 4000000;
    endcase
    return base + d;
  endfunction

  // result checker
  always @(posedge clk) begin
    velocity_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transaction: %0d %0d %0d",
                   out_linear_speed, out_angular_speed, out_nav_mode);
      end else begin
        want = pending_cmds.pop_front();
        if (out_linear_speed !== want.linear_speed ||
            out_angular_speed !== want.angular_speed ||
            out_nav_mode !== want.nav_mode) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: lin %0d/%0d ang %0d/%0d mode %0d/%0d (got/exp)",
                     out_linear_speed, want.linear_speed, out_angular_speed,
                     $signed(want.angular_speed), out_nav_mode, want.nav_mode);
        end
      end
    end
  end

  // receiver stalls in random bursts while idle_enable is set
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_enable && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
    out_ready <= (stall_left == 0);
  end

  initial begin
    pose_row_t directed[$];
    logic [31:0] gx, gy;
    int phase;
    reset_model();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at reset settings
    directed.push_back(fixed_row(tick_row(32'h7fffffff, 32'h80000000, 15'sd12868), 0, 0,
                                 gtg_pkg::MODE_STOPPED));
    directed.push_back(goal_row(0, 0));
    directed.push_back(fixed_row(tick_row(0, 0, 0), 0, 0, gtg_pkg::MODE_STOPPED));
    directed.push_back(goal_row(32'h00100000, 0));
    directed.push_back(tick_row(0, 0, 15'sd12868));
    directed.push_back(tick_row(0, 0, 15'sd100));
    directed.push_back(tick_row(0, 0, 15'h4000));
    directed.push_back(tick_row(0, 32'h00010000, 15'h3fff));
    directed.push_back(goal_row(32'h7fffffff, 32'h7fffffff));
    directed.push_back(tick_row(32'h80000000, 32'h80000000, -15'sd12868));
    directed.push_back(tick_row(32'h80000000, 32'h80000000, 0));
    directed.push_back(goal_row(32'h80000000, 32'h7fffffff));
    directed.push_back(tick_row(32'h7fffffff, 32'h80000000, 15'h7fff));
    directed.push_back(tick_row(0, 0, 0));
    directed.push_back(goal_row(32'hffff0000, 32'h00020000));
    directed.push_back(tick_row(32'hffff0000, 32'h00020000, 0));
    directed.push_back(tick_row(32'hffff0000, 32'h00020000, 0));
    foreach (directed[i]) send_item(directed[i]);
    wait_drained();

    // directed extremes of the registers
    write_reg(gtg_pkg::REG_ATTRACTION_GAIN, 20'd0);
    write_reg(gtg_pkg::REG_HEADING_GAIN, 20'hffff);
    write_reg(gtg_pkg::REG_MIN_SPEED, 20'hfffff);
    write_reg(gtg_pkg::REG_MAX_SPEED, 20'd0);
    write_reg(gtg_pkg::REG_TURN_THRESHOLD, 20'd0);
    write_reg(gtg_pkg::REG_TURN_RATE, 20'hffff);
    write_reg(gtg_pkg::REG_ARRIVE_TOLERANCE, 20'd0);
    write_reg(3'd7, 20'h12345);
    send_item(goal_row(32'h00050000, 32'hfffb0000));
    send_item(tick_row(0, 0, 15'sd12868));
    send_item(tick_row(32'h00050000, 32'hfffb0000, -15'sd5000));
    wait_drained();
    write_reg(gtg_pkg::REG_ATTRACTION_GAIN, 20'hffff);
    send_item(tick_row(32'h80000000, 32'h7fffffff, 15'sd3000));
    wait_drained();
    write_reg(gtg_pkg::REG_TURN_THRESHOLD, 20'd12868);
    write_reg(gtg_pkg::REG_ARRIVE_TOLERANCE, 20'hfffff);
    send_item(goal_row(0, 0));
    send_item(tick_row(32'h00100000, 0, 0));
    send_item(tick_row(32'h000fffff, 0, 0));
    wait_drained();

    // random phases with varying settings
    gx = 0; gy = 0;
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 10) idle_enable = 1'b0;
      write_reg(gtg_pkg::REG_ATTRACTION_GAIN,
                $urandom_range(0, 5) == 0 ? 20'($urandom_range(0, 1) * 16'hffff)
                                          : 20'($urandom_range(1, 2000)));
      write_reg(gtg_pkg::REG_HEADING_GAIN,
                $urandom_range(0, 4) == 0 ? 20'hffff : 20'($urandom_range(0, 65535)));
      write_reg(gtg_pkg::REG_MAX_SPEED,
                $urandom_range(0, 4) == 0 ? 20'hfffff : 20'($urandom_range(0, 200000)));
      write_reg(gtg_pkg::REG_MIN_SPEED,
                $urandom_range(0, 4) == 0 ? 20'hfffff : 20'($urandom_range(0, 20000)));
      write_reg(gtg_pkg::REG_ARRIVE_TOLERANCE,
                $urandom_range(0, 4) == 0 ? 20'hfffff : 20'($urandom_range(0, 100000)));
      write_reg(gtg_pkg::REG_TURN_THRESHOLD,
                $urandom_range(0, 4) == 0 ? 20'($urandom_range(0, 1) * 12868)
                                          : 20'($urandom_range(0, 16383)));
      write_reg(gtg_pkg::REG_TURN_RATE, 20'($urandom_range(0, 65535)));
      for (int n = 0; n < NUM_RANDOM / 12; n++) begin
        if ($urandom_range(0, 12) == 0) begin
          gx = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000000) - 2000000;
          gy = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000000) - 2000000;
          send_item(goal_row(gx, gy));
        end else begin
          send_item(tick_row(near(gx), near(gy), rand_yaw()));
        end
      end
      wait_drained();
    end

    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gtg_pkg.sv
hw/rtl/gtg_ctrl.sv
hw/rtl/gtg_dp.sv
hw/rtl/go_to_goal_velocity_controller.sv
tb/testbench.sv
